@@ sv/acs_pkg.sv @@
// Shared constants, register codes and controller/datapath interface types
// for the anchor chaining score block. No dependencies.

package acs_pkg;

    // Number of predecessor anchors held in the look-back window.
    localparam int WINDOW_DEPTH = 32;
    localparam int IDX_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int COUNT_W      = $clog2(WINDOW_DEPTH + 1);

    // Field widths.
    localparam int POS_W   = 31;
    localparam int SCORE_W = 31;
    localparam int K_W     = 8;
    localparam int COEF_W  = 16;
    localparam int PROD_W  = POS_W + COEF_W;
    localparam int FRAC_W  = 16;
    localparam int DIFF_W  = POS_W + 1;
    localparam int BEST_W  = SCORE_W + 1;
    localparam int OFFER_W = SCORE_W + 2;

    // Configuration port.
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_MATCH_BONUS_CAP = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GAP_COEF_Q16    = CFG_IDX_W'(1);

    localparam logic [K_W-1:0]    K_RESET    = K_W'(15);
    localparam logic [COEF_W-1:0] COEF_RESET = COEF_W'(9830);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             load;
        logic             issue;
        logic [IDX_W-1:0] rd_addr;
        logic             finish;
        logic [IDX_W-1:0] wr_addr;
    } acs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pipe_busy;
    } acs_status_t;

endpackage

@@ sv/acs_datapath.sv @@
// Datapath of the anchor chaining score block: configuration registers,
// window memory and the four-stage offer pipeline with the running maximum.
// Depends on acs_pkg.

module acs_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [acs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [acs_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [acs_pkg::POS_W-1:0]         ref_pos,
    input  logic [acs_pkg::POS_W-1:0]         query_pos,
    input  acs_pkg::acs_cmd_t                 cmd,
    output acs_pkg::acs_status_t              status,
    output logic [acs_pkg::SCORE_W-1:0]       score
);

    logic [acs_pkg::K_W-1:0]     k_reg;
    logic [acs_pkg::COEF_W-1:0]  coef_reg;
    logic [acs_pkg::POS_W-1:0]   x_reg;
    logic [acs_pkg::POS_W-1:0]   y_reg;

    logic [acs_pkg::POS_W-1:0]   win_ref   [acs_pkg::WINDOW_DEPTH];
    logic [acs_pkg::POS_W-1:0]   win_query [acs_pkg::WINDOW_DEPTH];
    logic [acs_pkg::SCORE_W-1:0] win_score [acs_pkg::WINDOW_DEPTH];

    logic v1_reg, v2_reg, v3_reg, v4_reg;

    logic [acs_pkg::POS_W-1:0]   rd_ref_reg;
    logic [acs_pkg::POS_W-1:0]   rd_query_reg;
    logic [acs_pkg::SCORE_W-1:0] rd_score_reg;

    logic [acs_pkg::DIFF_W-1:0]  dx_reg, dy_reg;
    logic [acs_pkg::DIFF_W-1:0]  dx_next, dy_next;
    logic [acs_pkg::SCORE_W-1:0] score2_reg;

    logic                        usable3_next, usable3_reg;
    logic [acs_pkg::POS_W-1:0]   dxm, dym, min_d;
    logic [acs_pkg::K_W-1:0]     alpha3_next, alpha3_reg;
    logic [acs_pkg::POS_W-1:0]   gap3_next, gap3_reg;
    logic [acs_pkg::SCORE_W-1:0] score3_reg;

    logic [acs_pkg::PROD_W-1:0]  prod;
    logic [acs_pkg::POS_W-1:0]   beta4_reg;
    logic                        usable4_reg;
    logic [acs_pkg::K_W-1:0]     alpha4_reg;
    logic [acs_pkg::SCORE_W-1:0] score4_reg;

    logic [acs_pkg::OFFER_W-1:0] offer;
    logic                        offer_wins;
    logic [acs_pkg::BEST_W-1:0]  best_reg, best_next;
    logic [acs_pkg::SCORE_W-1:0] final_score;
    logic [acs_pkg::SCORE_W-1:0] score_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg    <= acs_pkg::K_RESET;
            coef_reg <= acs_pkg::COEF_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                acs_pkg::REG_MATCH_BONUS_CAP: k_reg    <= cfg_data[acs_pkg::K_W-1:0];
                acs_pkg::REG_GAP_COEF_Q16:    coef_reg <= cfg_data[acs_pkg::COEF_W-1:0];
                default: ;
            endcase
        end
    end

    // Current anchor, captured when the item is accepted.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg <= ref_pos;
            y_reg <= query_pos;
        end
    end

    // Window memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            win_ref[cmd.wr_addr]   <= x_reg;
            win_query[cmd.wr_addr] <= y_reg;
            win_score[cmd.wr_addr] <= final_score;
        end
        if (cmd.issue)
        begin
            rd_ref_reg   <= win_ref[cmd.rd_addr];
            rd_query_reg <= win_query[cmd.rd_addr];
            rd_score_reg <= win_score[cmd.rd_addr];
        end
    end

    // Stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    assign status.pipe_busy = v1_reg | v2_reg | v3_reg | v4_reg;

    // Stage two: coordinate differences, with a sign bit each.
    assign dx_next = {1'b0, x_reg} - {1'b0, rd_ref_reg};
    assign dy_next = {1'b0, y_reg} - {1'b0, rd_query_reg};

    // Stage three: usability, alpha and the diagonal gap.
    assign dxm = dx_reg[acs_pkg::POS_W-1:0];
    assign dym = dy_reg[acs_pkg::POS_W-1:0];
    assign usable3_next = !dx_reg[acs_pkg::DIFF_W-1] && (dxm != '0) &&
                          !dy_reg[acs_pkg::DIFF_W-1] && (dym != '0);
    assign min_d       = (dxm < dym) ? dxm : dym;
    assign alpha3_next = (min_d < acs_pkg::POS_W'(k_reg)) ?
                         min_d[acs_pkg::K_W-1:0] : k_reg;
    assign gap3_next   = (dym > dxm) ? (dym - dxm) : (dxm - dym);

    // Stage four: gap penalty in Q16, truncated.
    assign prod = acs_pkg::PROD_W'(gap3_reg) * acs_pkg::PROD_W'(coef_reg);

    always_ff @(posedge clk)
    begin
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        score2_reg  <= rd_score_reg;

        usable3_reg <= usable3_next;
        alpha3_reg  <= alpha3_next;
        gap3_reg    <= gap3_next;
        score3_reg  <= score2_reg;

        beta4_reg   <= prod[acs_pkg::FRAC_W +: acs_pkg::POS_W];
        usable4_reg <= usable3_reg;
        alpha4_reg  <= alpha3_reg;
        score4_reg  <= score3_reg;
    end

    // Offer of one predecessor and the running maximum, which starts at k.
    assign offer = acs_pkg::OFFER_W'(score4_reg) + acs_pkg::OFFER_W'(alpha4_reg)
                 - acs_pkg::OFFER_W'(beta4_reg);
    assign offer_wins = !offer[acs_pkg::OFFER_W-1] &&
                        (offer[acs_pkg::BEST_W-1:0] > best_reg);

    always_comb
    begin
        best_next = best_reg;
        if (cmd.load)
            best_next = acs_pkg::BEST_W'(k_reg);
        else if (v4_reg && usable4_reg && offer_wins)
            best_next = offer[acs_pkg::BEST_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
    end

    // Saturate to the score width.
    assign final_score = best_reg[acs_pkg::BEST_W-1] ? '1 : best_reg[acs_pkg::SCORE_W-1:0];

    // Output register.
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
            score_reg <= final_score;
    end

    assign score = score_reg;

endmodule

@@ sv/acs_ctrl.sv @@
// Controller of the anchor chaining score block: handshakes, window
// occupancy, write slot and the scan sequence. Depends on acs_pkg.

module acs_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 chain_start,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  acs_pkg::acs_status_t status,
    output acs_pkg::acs_cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } state_t;

    state_t                          state_reg;
    logic [acs_pkg::COUNT_W-1:0]     rd_idx_reg;
    logic [acs_pkg::COUNT_W-1:0]     valid_count_reg;
    logic [acs_pkg::IDX_W-1:0]       wr_slot_reg;
    logic                            out_valid_reg;

    // Commands decoded from the state.
    always_comb
    begin
        cmd.load    = (state_reg == S_IDLE) && in_valid;
        cmd.issue   = (state_reg == S_SCAN);
        cmd.rd_addr = rd_idx_reg[acs_pkg::IDX_W-1:0];
        cmd.finish  = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);
        cmd.wr_addr = wr_slot_reg;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    // State, counters and the output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            rd_idx_reg      <= '0;
            valid_count_reg <= '0;
            wr_slot_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        rd_idx_reg <= '0;
                        if (chain_start)
                        begin
                            // A new chain empties the window before scoring.
                            valid_count_reg <= '0;
                            wr_slot_reg     <= '0;
                            state_reg       <= S_DRAIN;
                        end
                        else if (valid_count_reg == '0)
                            state_reg <= S_DRAIN;
                        else
                            state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    rd_idx_reg <= rd_idx_reg + acs_pkg::COUNT_W'(1);
                    if (rd_idx_reg == valid_count_reg - acs_pkg::COUNT_W'(1))
                        state_reg <= S_DRAIN;
                end
                S_DRAIN:
                begin
                    if (!status.pipe_busy)
                        state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (cmd.finish)
                    begin
                        if (wr_slot_reg == acs_pkg::IDX_W'(acs_pkg::WINDOW_DEPTH - 1))
                            wr_slot_reg <= '0;
                        else
                            wr_slot_reg <= wr_slot_reg + acs_pkg::IDX_W'(1);
                        if (valid_count_reg != acs_pkg::COUNT_W'(acs_pkg::WINDOW_DEPTH))
                            valid_count_reg <= valid_count_reg + acs_pkg::COUNT_W'(1);
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

@@ sv/anchor_chaining_score.sv @@
// Anchor chaining score, top level. An item scanned against n window entries
// (1 to 32) shows its score on out_valid once its offers leave the pipeline, and
// the next item is taken after that; a chain start or an empty window skips the
// scan. A result held by out_stall delays both. The window is read one entry per
// cycle into the four-stage offer pipeline. Asynchronous active-low reset empties
// the window and restores the default configuration; contents are kept.

module anchor_chaining_score (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [acs_pkg::POS_W-1:0]         ref_pos,
    input  logic [acs_pkg::POS_W-1:0]         query_pos,
    input  logic                              chain_start,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [acs_pkg::SCORE_W-1:0]       score,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [acs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [acs_pkg::CFG_DATA_W-1:0]    cfg_data
);

    acs_pkg::acs_cmd_t    cmd;
    acs_pkg::acs_status_t status;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    acs_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .chain_start (chain_start),
        .in_stall    (in_stall),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .cmd         (cmd)
    );

    acs_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ref_pos   (ref_pos),
        .query_pos (query_pos),
        .cmd       (cmd),
        .status    (status),
        .score     (score)
    );

endmodule

@@ sv/acs_checker.sv @@
// Port-level checks for the anchor chaining score block, and the bind that
// attaches them to the top level. Depends on acs_pkg.

module acs_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic                              chain_start,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic [acs_pkg::SCORE_W-1:0]       score
);

    // A stalled result item holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(score))
        else $error("stalled score changed");

    // One item at a time: the block is busy after accepting an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second item taken while busy");

    // A chain start scans nothing; its result follows drain and done.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && chain_start |-> ##3 out_valid)
        else $error("chain start result late");

    // A new result appears only once the block is free for the next item.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_stall)
        else $error("result shown while still busy");

endmodule

bind anchor_chaining_score acs_checker u_acs_checker (.*);

@@ test/testbench.sv @@
// Self-checking testbench for the anchor chaining score block.
// Depends on acs_pkg (sv/acs_pkg.sv) and the anchor_chaining_score top level.

module testbench;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int DRAIN_CYCLES  = 48;
    localparam int LONG_HOLD     = 400;
    localparam longint SCORE_TOP = 64'h7FFF_FFFF;

    localparam logic [acs_pkg::POS_W-1:0]     POS_MAX          = '1;
    localparam logic [acs_pkg::CFG_IDX_W-1:0] REG_PAST_END     = acs_pkg::CFG_IDX_W'(2);
    localparam logic [acs_pkg::CFG_IDX_W-1:0] REG_TOP_OF_RANGE = '1;

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_stall;
    logic [acs_pkg::POS_W-1:0]       ref_pos;
    logic [acs_pkg::POS_W-1:0]       query_pos;
    logic                            chain_start;
    logic                            out_valid;
    logic                            out_stall;
    logic [acs_pkg::SCORE_W-1:0]     score;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [acs_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [acs_pkg::CFG_DATA_W-1:0]  cfg_data;

    // Predicted scoring state: configuration and the look-back window.
    logic [acs_pkg::K_W-1:0]         bonus_cap = acs_pkg::K_RESET;
    logic [acs_pkg::COEF_W-1:0]      gap_coef  = acs_pkg::COEF_RESET;
    logic [acs_pkg::POS_W-1:0]       win_ref   [acs_pkg::WINDOW_DEPTH];
    logic [acs_pkg::POS_W-1:0]       win_query [acs_pkg::WINDOW_DEPTH];
    logic [acs_pkg::SCORE_W-1:0]     win_score [acs_pkg::WINDOW_DEPTH];
    int                              held      = 0;
    int                              next_slot = 0;

    logic [acs_pkg::SCORE_W-1:0]     expected_scores [$];
    int                              errors          = 0;
    int                              anchors_sent    = 0;
    int                              scores_checked  = 0;
    int                              register_writes = 0;
    int                              cycle_count     = 0;
    bit                              idle_free       = 1'b0;
    bit                              hold_request    = 1'b0;

    anchor_chaining_score dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .ref_pos     (ref_pos),
        .query_pos   (query_pos),
        .chain_start (chain_start),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .score       (score),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Scores one anchor against the window and then enters it into the window.
    function automatic logic [acs_pkg::SCORE_W-1:0] predict_score(
        input logic [acs_pkg::POS_W-1:0] x,
        input logic [acs_pkg::POS_W-1:0] y,
        input logic start);
        longint best;
        longint dx;
        longint dy;
        longint alpha;
        longint beta;
        longint offer;
        int i;
        if (start)
        begin
            held = 0;
            next_slot = 0;
        end
        best = longint'(bonus_cap);
        for (i = 0; i < held; i++)
        begin
            dx = longint'(x) - longint'(win_ref[i]);
            dy = longint'(y) - longint'(win_query[i]);
            if (dx > 0 && dy > 0)
            begin
                alpha = (dx < dy) ? dx : dy;
                if (alpha > longint'(bonus_cap))
                    alpha = longint'(bonus_cap);
                beta = (((dy > dx) ? dy - dx : dx - dy) * longint'(gap_coef)) >>> 16;
                offer = longint'(win_score[i]) + alpha - beta;
                if (offer > best)
                    best = offer;
            end
        end
        if (best > SCORE_TOP)
            best = SCORE_TOP;
        win_ref[next_slot] = x;
        win_query[next_slot] = y;
        win_score[next_slot] = best[acs_pkg::SCORE_W-1:0];
        next_slot = (next_slot + 1) % acs_pkg::WINDOW_DEPTH;
        if (held < acs_pkg::WINDOW_DEPTH)
            held++;
        return best[acs_pkg::SCORE_W-1:0];
    endfunction

    // Offers one anchor after a random gap and records its score once accepted.
    task automatic send_anchor(input logic [acs_pkg::POS_W-1:0] x,
                               input logic [acs_pkg::POS_W-1:0] y,
                               input logic start);
        int gap;
        gap = idle_free ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        ref_pos     <= x;
        query_pos   <= y;
        chain_start <= start;
        do
            @(posedge clk);
        while (in_stall);
        expected_scores.push_back(predict_score(x, y, start));
        anchors_sent++;
        @(negedge clk);
    endtask

    // Lets every outstanding score arrive and the block settle.
    task automatic wait_for_scores();
        in_valid <= 1'b0;
        while (expected_scores.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic [acs_pkg::CFG_IDX_W-1:0] reg_index,
                                  input logic [acs_pkg::CFG_DATA_W-1:0] reg_value);
        cfg_valid <= 1'b1;
        cfg_index <= reg_index;
        cfg_data  <= reg_value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (reg_index)
            acs_pkg::REG_MATCH_BONUS_CAP: bonus_cap = reg_value[acs_pkg::K_W-1:0];
            acs_pkg::REG_GAP_COEF_Q16:    gap_coef = reg_value;
            default:                      ;
        endcase
        register_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_scoring(input logic [acs_pkg::K_W-1:0] k,
                               input logic [acs_pkg::COEF_W-1:0] coef);
        wait_for_scores();
        write_register(acs_pkg::REG_MATCH_BONUS_CAP, acs_pkg::CFG_DATA_W'(k));
        write_register(acs_pkg::REG_GAP_COEF_Q16, coef);
    endtask

    // Random chains: mostly well-formed forward steps, with some large gaps,
    // some overlapping steps and some unrelated anchors mixed in.
    task automatic run_chains(input int anchors);
        int sent;
        int len;
        int j;
        int pick;
        int dx;
        int dy;
        logic [acs_pkg::POS_W-1:0] x;
        logic [acs_pkg::POS_W-1:0] y;
        sent = 0;
        while (sent < anchors)
        begin
            len = $urandom_range(1, 80);
            x = acs_pkg::POS_W'($urandom());
            y = acs_pkg::POS_W'($urandom());
            for (j = 0; j < len && sent < anchors; j++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 10 && j > 0)
                begin
                    send_anchor(acs_pkg::POS_W'($urandom()), acs_pkg::POS_W'($urandom()),
                                1'($urandom_range(0, 1)));
                end
                else
                begin
                    if (j > 0)
                    begin
                        if (pick < 75)
                        begin
                            dx = $urandom_range(1, 300);
                            dy = dx + $urandom_range(0, 40) - 20;
                        end
                        else if (pick < 88)
                        begin
                            dx = $urandom_range(1, 1 << 20);
                            dy = $urandom_range(1, 1 << 20);
                        end
                        else
                        begin
                            dx = $urandom_range(0, 60) - 30;
                            dy = $urandom_range(0, 60) - 30;
                        end
                        x = acs_pkg::POS_W'(int'(x) + dx);
                        y = acs_pkg::POS_W'(int'(y) + dy);
                    end
                    send_anchor(x, y, j == 0);
                end
                sent++;
            end
        end
    endtask

    // Hand-picked anchors under the reset configuration.
    task automatic test_directed_anchors();
        int i;
        send_anchor(0, 0, 1'b1);
        send_anchor(1, 1, 1'b0);
        send_anchor(1, 9, 1'b0);
        send_anchor(0, 20, 1'b0);
        send_anchor(40, 40, 1'b0);
        send_anchor(POS_MAX, POS_MAX, 1'b0);
        send_anchor(POS_MAX, 0, 1'b0);
        send_anchor(0, POS_MAX, 1'b0);
        send_anchor(POS_MAX, POS_MAX, 1'b1);
        send_anchor(0, 0, 1'b0);
        send_anchor(1, POS_MAX, 1'b0);
        send_anchor(0, 0, 1'b1);
        send_anchor(POS_MAX, POS_MAX - acs_pkg::POS_W'(1), 1'b0);
        // A tight diagonal chain whose scores keep growing.
        for (i = 0; i < 10; i++)
            send_anchor(acs_pkg::POS_W'(100 + i * 5), acs_pkg::POS_W'(200 + i * 6), i == 0);
        wait_for_scores();
    endtask

    // Register writes: ignored upper bits, indexes past the end, extremes.
    task automatic test_register_writes();
        write_register(acs_pkg::REG_MATCH_BONUS_CAP, 16'hA507);
        write_register(REG_PAST_END, 16'hFFFF);
        write_register(REG_TOP_OF_RANGE, 16'h0000);
        run_chains(12);
        set_scoring(8'd255, 16'hFFFF);
        send_anchor(0, 0, 1'b1);
        send_anchor(POS_MAX, POS_MAX, 1'b0);
        send_anchor(POS_MAX, POS_MAX, 1'b0);
        run_chains(10);
        set_scoring(8'd0, 16'h0000);
        run_chains(10);
        wait_for_scores();
    endtask

    // Long random runs under several settings, one of them with no idling.
    task automatic test_random_chains();
        set_scoring(acs_pkg::K_RESET, acs_pkg::COEF_RESET);
        run_chains(290);
        set_scoring(8'd0, 16'h0000);
        run_chains(290);
        set_scoring(8'd255, 16'hFFFF);
        idle_free = 1'b1;
        run_chains(290);
        idle_free = 1'b0;
        set_scoring(8'd255, 16'h0000);
        run_chains(290);
        set_scoring(8'd1, 16'h0001);
        run_chains(290);
        set_scoring(acs_pkg::K_W'($urandom_range(0, 255)),
                    acs_pkg::COEF_W'($urandom_range(0, 65535)));
        run_chains(290);
        wait_for_scores();
    endtask

    // The receiver holds off for a long stretch while anchors keep coming.
    task automatic test_back_pressure();
        set_scoring(8'd40, 16'd3000);
        idle_free = 1'b1;
        hold_request = 1'b1;
        run_chains(80);
        idle_free = 1'b0;
        wait_for_scores();
    endtask

    initial
    begin : stimulus
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        ref_pos     = '0;
        query_pos   = '0;
        chain_start = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed_anchors();
        test_register_writes();
        test_random_chains();
        test_back_pressure();
        wait_for_scores();
        $display("Sent %0d anchors and checked %0d scores across %0d register writes,",
                 anchors_sent, scores_checked, register_writes);
        $display("including chain starts, window wrap, extreme settings and a long stall.");
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Result side: a random stall before each item, and one long hold-off on request.
    initial
    begin : receiver
        int stall_cycles;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall_cycles = idle_free ? 0 : $urandom_range(0, 6);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_cycles += LONG_HOLD;
            end
            if (stall_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_cycles) @(negedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            @(negedge clk);
        end
    end

    // Compares each accepted score with the oldest prediction.
    always @(posedge clk)
    begin : score_check
        logic [acs_pkg::SCORE_W-1:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_scores.size() == 0)
            begin
                $display("%0t: unexpected score: expected none, actual %0d", $time, score);
                errors++;
            end
            else
            begin
                want = expected_scores.pop_front();
                if (score !== want)
                begin
                    $display("%0t: score mismatch: expected %0d, actual %0d",
                             $time, want, score);
                    errors++;
                end
            end
            scores_checked++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d scores outstanding",
                     $time, expected_scores.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

endmodule
